[rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic {
    CFG_FG_COLOR = 1'b0,
    CFG_BG_COLOR = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESP
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
    logic        scrolled;
  } rsp_t;

endpackage

[rtl/tcw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/text_console_writer.sv]
// Text console engine: a screen of character cells in RAM, a cursor and color registers.
//
// After reset the block sweeps the screen RAM to zero and stalls requests
// meanwhile; configuration writes are taken at any time. A character write,
// newline, backspace or cell read makes at most one RAM access when it is
// accepted, and the response state then loads the result register once the
// output register is free. A clear screen request sweeps the RAM once, one cell
// per cycle. A printable character written with the cursor past the end scrolls
// the screen through the one write port and one read port of the RAM, one cell
// per cycle. The next request is accepted while a finished result still waits
// in the output register.
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcw_pkg::req_t     in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcw_pkg::rsp_t     out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  tcw_pkg::cfg_reg_e cfg_index_i,
  input  logic [3:0]        cfg_data_i
);

  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS + 1);
  localparam int unsigned RAW   = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] CELLS_A    = AW'(CELLS);
  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_ROW_A = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);

  state_e         state_q, state_d;
  logic [AW-1:0]  cursor_q, cursor_d;
  logic [CW-1:0]  col_q, col_d;
  logic [AW-1:0]  ptr_q, ptr_d;
  logic [15:0]    cell_q, cell_d;
  logic [RAW-1:0] rd_addr_q, rd_addr_d;
  logic           rd_ok_q, rd_ok_d;
  logic           is_read_q, is_read_d;
  logic           scrolled_q, scrolled_d;
  logic [3:0]     fg_q, bg_q;
  logic           out_valid_q, out_valid_d;
  rsp_t           out_q, out_d;

  logic           ram_we;
  logic [RAW-1:0] ram_waddr;
  logic [15:0]    ram_wdata;
  logic [RAW-1:0] ram_raddr;
  logic [15:0]    ram_rdata;

  logic           in_fire;
  logic           out_free;
  logic           printable;
  logic [15:0]    in_cell;
  logic [15:0]    space_cell;
  logic [AW:0]    nl_sum;
  logic [AW-1:0]  nl_next;
  logic [AW-1:0]  ptr_m1;

  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign printable  = (in_req_i.char_code != CODE_NEWLINE) &&
                      (in_req_i.char_code != CODE_BACKSPACE);
  assign in_cell    = {bg_q, fg_q, in_req_i.char_code};
  assign space_cell = {bg_q, fg_q, CODE_SPACE};
  assign nl_sum     = {1'b0, cursor_q} - (AW + 1)'(col_q) + (AW + 1)'(COLUMNS);
  assign nl_next    = (nl_sum > (AW + 1)'(CELLS)) ? CELLS_A : nl_sum[AW-1:0];
  assign ptr_m1     = ptr_q - AW'(1);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (ptr_q == CELLS_A - AW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_req_i.func)
            FUNC_WRITE: begin
              state_d = (printable && cursor_q == CELLS_A) ? ST_SCROLL : ST_RESP;
            end
            FUNC_CLEAR: state_d = ST_CLEAR;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_SCROLL: begin
        if (ptr_q == CELLS_A) begin
          state_d = ST_RESP;
        end
      end
      ST_CLEAR: begin
        if (ptr_q == CELLS_A - AW'(1)) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cursor_d    = cursor_q;
    col_d       = col_q;
    ptr_d       = ptr_q;
    cell_d      = cell_q;
    rd_addr_d   = rd_addr_q;
    rd_ok_d     = rd_ok_q;
    is_read_d   = is_read_q;
    scrolled_d  = scrolled_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = rd_addr_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[RAW-1:0];
        ptr_d     = ptr_q + AW'(1);
      end
      ST_IDLE: begin
        ptr_d = '0;
        if (in_fire) begin
          scrolled_d = 1'b0;
          is_read_d  = 1'b0;
          rd_ok_d    = 1'b0;
          unique case (in_req_i.func)
            FUNC_WRITE: begin
              if (in_req_i.char_code == CODE_NEWLINE) begin
                cursor_d = nl_next;
                col_d    = '0;
              end else if (in_req_i.char_code == CODE_BACKSPACE) begin
                if (cursor_q != '0) begin
                  cursor_d  = cursor_q - AW'(1);
                  col_d     = (col_q == '0) ? COL_LAST : col_q - CW'(1);
                  ram_we    = 1'b1;
                  ram_waddr = RAW'(cursor_q - AW'(1));
                  ram_wdata = space_cell;
                end
              end else if (cursor_q == CELLS_A) begin
                cell_d = in_cell;
              end else begin
                cursor_d  = cursor_q + AW'(1);
                col_d     = (col_q == COL_LAST) ? '0 : col_q + CW'(1);
                ram_we    = 1'b1;
                ram_waddr = cursor_q[RAW-1:0];
                ram_wdata = in_cell;
              end
            end
            FUNC_CLEAR: begin
              cursor_d = '0;
              col_d    = '0;
            end
            FUNC_READ: begin
              is_read_d = 1'b1;
              rd_ok_d   = 32'(in_req_i.cell_index) < 32'(CELLS);
              rd_addr_d = RAW'(in_req_i.cell_index);
              ram_raddr = RAW'(in_req_i.cell_index);
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCROLL: begin
        ram_raddr = (ptr_q < LAST_ROW_A) ? RAW'(ptr_q + COLS_A) : '0;
        if (ptr_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_m1[RAW-1:0];
          if (ptr_m1 < LAST_ROW_A) begin
            ram_wdata = ram_rdata;
          end else if (ptr_m1 == LAST_ROW_A) begin
            ram_wdata = cell_q;
          end
        end
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == CELLS_A) begin
          cursor_d   = LAST_ROW_A + AW'(1);
          col_d      = CW'(1);
          scrolled_d = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.cursor_pos = 11'(cursor_q);
          out_d.cell_value = (is_read_q && rd_ok_q) ? ram_rdata : 16'd0;
          out_d.scrolled   = scrolled_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cursor_q    <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      fg_q        <= 4'hF;
      bg_q        <= 4'h0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_FG_COLOR: fg_q <= cfg_data_i;
          CFG_BG_COLOR: bg_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q     <= cell_d;
    rd_addr_q  <= rd_addr_d;
    rd_ok_q    <= rd_ok_d;
    is_read_q  <= is_read_d;
    scrolled_q <= scrolled_d;
    out_q      <= out_d;
  end

  // The cursor never runs past the end of the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cursor_q <= CELLS_A)
    else $error("cursor beyond end of screen");

  // The column tracker always stays inside one row.
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(col_q) < 32'(COLUMNS))
    else $error("column tracker out of range");

  // Every RAM write lands inside the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < 32'(CELLS)))
    else $error("screen write out of range");

  // A new result only appears after the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside the response state");

  // An accepted request blocks the input until it has been handled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request accepted back to back");

endmodule

[test/text_console_writer_tb.sv]
// Self-checking testbench for text_console_writer with a scoreboard that models the screen.
module text_console_writer_tb;

  import tcw_pkg::*;

  class console_scoreboard;
    localparam int unsigned COLS  = COLUMNS_DEF;
    localparam int unsigned CELLS = COLUMNS_DEF * ROWS_DEF;

    logic [15:0] screen [CELLS];
    int unsigned cursor;
    logic [3:0]  fg;
    logic [3:0]  bg;
    rsp_t        console_rsp_q[$];
    int          errors;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor = 0;
      fg = 4'd15;
      bg = 4'd0;
      errors = 0;
    endfunction

    function void write_color(cfg_reg_e idx, logic [3:0] val);
      if (idx == CFG_FG_COLOR) fg = val;
      else bg = val;
    endfunction

    function logic [15:0] colored(logic [7:0] code);
      return {bg, fg, code};
    endfunction

    function int pending();
      return console_rsp_q.size();
    endfunction

    function void apply_request(req_t r);
      rsp_t e;
      e = '0;
      if (cursor > CELLS) cursor = CELLS;
      case (r.func)
        FUNC_WRITE: begin
          if (r.char_code == CODE_NEWLINE) begin
            cursor += COLS - (cursor % COLS);
            if (cursor > CELLS) cursor = CELLS;
          end else if (r.char_code == CODE_BACKSPACE) begin
            if (cursor > 0) begin
              cursor--;
              screen[cursor] = colored(CODE_SPACE);
            end
          end else begin
            if (cursor >= CELLS) begin
              for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
              for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
              cursor = CELLS - COLS;
              e.scrolled = 1'b1;
            end
            screen[cursor] = colored(r.char_code);
            cursor++;
          end
        end
        FUNC_CLEAR: begin
          foreach (screen[i]) screen[i] = '0;
          cursor = 0;
        end
        FUNC_READ: begin
          if (r.cell_index < CELLS) e.cell_value = screen[r.cell_index];
        end
        default: begin
        end
      endcase
      e.cursor_pos = 11'(cursor);
      console_rsp_q.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (console_rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Response with nothing outstanding: cursor %0d cell %h scrolled %0d",
                   got.cursor_pos, got.cell_value, got.scrolled);
        return;
      end
      e = console_rsp_q.pop_front();
      if (got.cursor_pos !== e.cursor_pos || got.cell_value !== e.cell_value ||
          got.scrolled !== e.scrolled) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected cursor %0d cell %h scrolled %0d, got %0d %h %0d",
                   e.cursor_pos, e.cell_value, e.scrolled,
                   got.cursor_pos, got.cell_value, got.scrolled);
      end
    endfunction
  endclass

  localparam longint LIMIT_CYCLES = 3 * (2000 + 1000 * (2002 + 17 + 17 + 2));

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  req_t     in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rsp_t     out_rsp_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  cfg_reg_e cfg_index_i;
  logic [3:0] cfg_data_i;

  console_scoreboard sb = new();
  bit quiet;
  int stall_left;
  int stall_calm;

  text_console_writer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_calm = $urandom_range(50, 300);
    end else if (stall_calm > 0) begin
      out_stall_i <= 1'b0;
      stall_calm--;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
  end

  function automatic req_t request(func_e f, logic [7:0] code, logic [10:0] idx);
    req_t r;
    r.func = f;
    r.char_code = code;
    r.cell_index = idx;
    return r;
  endfunction

  task automatic send(req_t r);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.apply_request(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_color(cfg_reg_e idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_color(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] printable_code();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CODE_NEWLINE || c == CODE_BACKSPACE) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [10:0] read_index();
    int k;
    k = $urandom_range(0, 15);
    if (k < 12) return 11'($urandom_range(0, 1999));
    if (k < 14) return 11'(sb.cursor > 0 ? sb.cursor - 1 : 0);
    return 11'($urandom_range(2000, 2047));
  endfunction

  task automatic run_traffic(int count);
    int made;
    int kind;
    int len;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(1, 90);
        for (int i = 0; i < len && made < count; i++, made++)
          send(request(FUNC_WRITE, printable_code(), 11'($urandom)));
        if (made < count && $urandom_range(0, 3) != 0) begin
          send(request(FUNC_WRITE, CODE_NEWLINE, 11'($urandom)));
          made++;
        end
      end else if (kind < 60) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len && made < count; i++, made++)
          send(request(FUNC_WRITE, CODE_NEWLINE, 11'($urandom)));
      end else if (kind < 70) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len && made < count; i++, made++)
          send(request(FUNC_WRITE, CODE_BACKSPACE, 11'($urandom)));
      end else if (kind < 90) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len && made < count; i++, made++)
          send(request(FUNC_READ, 8'($urandom), read_index()));
      end else if (kind < 96) begin
        send(request(FUNC_WRITE, 8'($urandom), 11'($urandom)));
        made++;
      end else if (kind < 98) begin
        send(request(FUNC_CLEAR, 8'($urandom), 11'($urandom)));
        made++;
      end else begin
        send(request(func_e'(2'b11), 8'($urandom), 11'($urandom)));
        made++;
      end
    end
  endtask

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("text_console_writer test failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FG_COLOR;
    cfg_data_i = '0;
    quiet = 1'b0;
    stall_left = 0;
    stall_calm = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(request(FUNC_READ, 8'd0, 11'd0));
    send(request(FUNC_WRITE, 8'h00, 11'd0));
    send(request(FUNC_WRITE, 8'hFF, 11'h7FF));
    send(request(FUNC_WRITE, CODE_BACKSPACE, 11'd0));
    send(request(FUNC_WRITE, CODE_BACKSPACE, 11'd0));
    send(request(FUNC_WRITE, CODE_BACKSPACE, 11'd0));
    send(request(FUNC_WRITE, CODE_NEWLINE, 11'd0));
    send(request(FUNC_WRITE, 8'd65, 11'd0));
    send(request(FUNC_WRITE, CODE_NEWLINE, 11'd0));
    send(request(FUNC_READ, 8'hFF, 11'd80));
    send(request(FUNC_READ, 8'd0, 11'd1));
    send(request(FUNC_READ, 8'd0, 11'd1999));
    send(request(FUNC_READ, 8'd0, 11'h7FF));
    send(request(func_e'(2'b11), 8'd0, 11'd0));
    send(request(FUNC_CLEAR, 8'd0, 11'd0));
    send(request(FUNC_READ, 8'd0, 11'd80));
    drain();

    set_color(CFG_FG_COLOR, 4'd0);
    set_color(CFG_BG_COLOR, 4'd0);
    run_traffic(280);
    drain();

    set_color(CFG_FG_COLOR, 4'd15);
    set_color(CFG_BG_COLOR, 4'd15);
    run_traffic(280);
    drain();

    set_color(CFG_BG_COLOR, 4'($urandom));
    set_color(CFG_FG_COLOR, 4'($urandom));
    run_traffic(250);
    drain();

    quiet = 1'b1;
    set_color(CFG_FG_COLOR, 4'($urandom));
    set_color(CFG_BG_COLOR, 4'($urandom));
    run_traffic(120);
    drain();

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("text_console_writer test passed");
    end else begin
      $display("text_console_writer test failed");
    end
    $finish;
  end
endmodule
